[rtl/assert_macros.svh]
// Assertion helpers shared by the block's modules.
// Each expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CHK_ASSERT(lbl, prop, msg)
`define CHK_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/oahm_pkg.sv]
package oahm_pkg;

  // Default slot count
  localparam int TABLE_SLOTS_DEF = 32;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int KEY_W   = 31;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 3;
  localparam int ENTRY_W = 6;

  // Home slot reduction: reciprocal multiply for the quotient, then multiply back and subtract
  localparam int MOD_STEPS = 2;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  // Request codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RSVD   = 2'd3;

  // Result codes
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_UPDATED  = 3'd1;
  localparam logic [ST_W-1:0] ST_DELETED  = 3'd2;
  localparam logic [ST_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd5;

  // Slot marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;      // clear one mark entry
    logic load;        // capture the request
    logic mod_step;    // one remainder step
    logic probe_init;  // start the probe from the home slot
    logic probe_en;    // issue and check slots
    logic commit;      // write back and load the result register
  } oahm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic skip_probe;
    logic probe_done;
    logic out_free;
  } oahm_sts_t;

endpackage

[rtl/open_addressing_hash_map_unit.sv]
// Open-addressing hash map, linear probing with tombstones.
// Input channel (in_valid/in_ready): action (insert, delete, lookup), key, value.
// Result channel (out_valid/out_ready): status, value_out, entry_count, one
// result per item, in order.
// An item runs alone: the home slot (key modulo TABLE_SLOTS) is found by
// a reciprocal multiply for the quotient, then multiply back and subtract; the
// probe then reads one slot per cycle from the slot memories' single read port,
// checking each on the cycle after its read.
// A probe visits k slots, 1 <= k <= TABLE_SLOTS; the unused action code
// skips the probe. A new item is taken in the cycle after the previous
// result is loaded.
// After reset the mark store is swept to empty, one slot a cycle, through
// every slot; in_ready stays low meanwhile.
// A result waits in the output register while out_ready is low; the next item
// is still accepted and worked on, and holds at write-back until the output
// register is free, so the table is updated only as results are taken.
module open_addressing_hash_map_unit
  import oahm_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ACT_W-1:0]        in_action,
  input  logic [KEY_W-1:0]        in_key,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ST_W-1:0]         out_status,
  output logic signed [VAL_W-1:0] out_value_out,
  output logic [ENTRY_W-1:0]      out_entry_count
);

  oahm_cmd_t cmd;
  oahm_sts_t sts;

  oahm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  oahm_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_value_out   (out_value_out),
    .out_entry_count (out_entry_count),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

[rtl/oahm_ctrl.sv]
`include "assert_macros.svh"

module oahm_ctrl
  import oahm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  oahm_sts_t sts,
  output oahm_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_PROBE  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          if (sts.skip_probe) begin
            state_nxt = S_COMMIT;
          end else begin
            cmd.probe_init = 1'b1;
            state_nxt      = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        cmd.probe_en = 1'b1;
        if (sts.probe_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        // wait here while the previous result is still held
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // One item at a time
  `CHK_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready, "item taken while busy")
  // No write-back while the mark store is being swept
  `CHK_ASSERT(a_no_commit_in_clear, (state_r == S_CLEAR) |-> !cmd.commit,
              "commit during clearing pass")

endmodule

[rtl/oahm_dpath.sv]
`include "assert_macros.svh"

module oahm_dpath
  import oahm_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [ACT_W-1:0]        in_action,
  input  logic [KEY_W-1:0]        in_key,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ST_W-1:0]         out_status,
  output logic signed [VAL_W-1:0] out_value_out,
  output logic [ENTRY_W-1:0]      out_entry_count,
  input  oahm_cmd_t               cmd,
  output oahm_sts_t               sts
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(TABLE_SLOTS);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(TABLE_SLOTS - 1);
  localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_STEPS - 1);

  // Reciprocal of the slot count, rounded up; exact quotient for every 31-bit key
  localparam int PROD_W = 2 * KEY_W + 1;
  localparam int RCP_SH = KEY_W + IDX_W;
  localparam int QUO_W  = PROD_W - RCP_SH;
  localparam logic [KEY_W:0] RECIP =
    (KEY_W + 1)'(((64'd1 << RCP_SH) + 64'(TABLE_SLOTS - 1)) / 64'(TABLE_SLOTS));

  // Slot stores
  logic [KEY_W-1:0]        key_mem  [TABLE_SLOTS];
  logic signed [VAL_W-1:0] val_mem  [TABLE_SLOTS];
  logic [1:0]              mark_mem [TABLE_SLOTS];

  // Request
  logic [ACT_W-1:0]        act_r;
  logic [KEY_W-1:0]        key_r;
  logic signed [VAL_W-1:0] val_r;

  // Remainder unit
  logic [PROD_W-1:0]    quo_prod;
  logic [QUO_W-1:0]     quo_r;
  logic [KEY_W-1:0]     quo_mul;
  logic [KEY_W-1:0]     rem_full;
  logic [IDX_W-1:0]     rem_nxt;
  logic [MOD_CNT_W-1:0] mod_cnt_r;

  // Probe issue and check
  logic [IDX_W-1:0]        iss_idx_r;
  logic [CNT_W-1:0]        iss_cnt_r;
  logic                    rd_en;
  logic                    chk_vld_r;
  logic [IDX_W-1:0]        chk_idx_r;
  logic [CNT_W-1:0]        chk_cnt_r;
  logic [1:0]              mark_q;
  logic [KEY_W-1:0]        key_q;
  logic signed [VAL_W-1:0] val_q;
  logic                    chk_live;
  logic                    chk_empty;
  logic                    chk_hit;
  logic                    chk_last;

  // Probe outcome
  logic                    match_r;
  logic [IDX_W-1:0]        match_idx_r;
  logic signed [VAL_W-1:0] hit_val_r;
  logic                    free_vld_r;
  logic [IDX_W-1:0]        free_idx_r;

  // Write-back
  logic [IDX_W-1:0]        clr_idx_r;
  logic [CNT_W-1:0]        live_count_r;
  logic [CNT_W-1:0]        cnt_nxt;
  logic [ST_W-1:0]         st_c;
  logic signed [VAL_W-1:0] vout_c;
  logic                    key_we;
  logic                    val_we;
  logic                    mark_we_c;
  logic [1:0]              mark_wd_c;
  logic [IDX_W-1:0]        wr_idx;
  logic                    mark_we;
  logic [IDX_W-1:0]        mark_wa;
  logic [1:0]              mark_wd;
  logic                    ins_new;

  // Result register
  logic                    out_valid_r;
  logic [ST_W-1:0]         out_status_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [ENTRY_W-1:0]      out_count_r;

  // Home slot: quotient registered first, remainder on the following step
  assign quo_prod = PROD_W'(key_r) * PROD_W'(RECIP);
  assign quo_mul  = KEY_W'(quo_r) * KEY_W'(TABLE_SLOTS);
  assign rem_full = key_r - quo_mul;
  assign rem_nxt  = rem_full[IDX_W-1:0];

  // Slot check on the registered read data
  assign rd_en     = cmd.probe_en && (iss_cnt_r != CNT_FULL);
  assign chk_live  = (mark_q == MARK_LIVE);
  assign chk_empty = (mark_q == MARK_EMPTY);
  assign chk_hit   = chk_live && (key_q == key_r);
  assign chk_last  = (chk_cnt_r == CNT_LAST);

  // Outcome of the request
  always_comb begin
    st_c      = ST_NOTFOUND;
    vout_c    = '0;
    key_we    = 1'b0;
    val_we    = 1'b0;
    mark_we_c = 1'b0;
    mark_wd_c = MARK_EMPTY;
    cnt_nxt   = live_count_r;
    wr_idx    = match_r ? match_idx_r : free_idx_r;
    case (act_r)
      ACT_INSERT: begin
        if (match_r) begin
          st_c   = ST_UPDATED;
          val_we = 1'b1;
        end else if (free_vld_r) begin
          st_c      = ST_INSERTED;
          key_we    = 1'b1;
          val_we    = 1'b1;
          mark_we_c = 1'b1;
          mark_wd_c = MARK_LIVE;
          cnt_nxt   = live_count_r + 1'b1;
        end else begin
          st_c = ST_FULL;
        end
      end
      ACT_DELETE: begin
        if (match_r) begin
          st_c      = ST_DELETED;
          vout_c    = hit_val_r;
          mark_we_c = 1'b1;
          mark_wd_c = MARK_TOMB;
          if (live_count_r != '0) cnt_nxt = live_count_r - 1'b1;
        end
      end
      ACT_LOOKUP: begin
        if (match_r) begin
          st_c   = ST_FOUND;
          vout_c = hit_val_r;
        end
      end
      default: ;
    endcase
  end

  assign ins_new = (st_c == ST_INSERTED);

  // Mark store write port: clearing pass or write-back
  always_comb begin
    mark_we = 1'b0;
    mark_wa = wr_idx;
    mark_wd = mark_wd_c;
    if (cmd.clr_en) begin
      mark_we = 1'b1;
      mark_wa = clr_idx_r;
      mark_wd = MARK_EMPTY;
    end else if (cmd.commit && mark_we_c) begin
      mark_we = 1'b1;
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (rd_en) mark_q <= mark_mem[iss_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && key_we) key_mem[wr_idx] <= key_r;
    if (rd_en) key_q <= key_mem[iss_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && val_we) val_mem[wr_idx] <= val_r;
    if (rd_en) val_q <= val_mem[iss_idx_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r    <= '0;
      mod_cnt_r    <= '0;
      iss_cnt_r    <= '0;
      chk_vld_r    <= 1'b0;
      chk_cnt_r    <= '0;
      match_r      <= 1'b0;
      free_vld_r   <= 1'b0;
      live_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clr_en) clr_idx_r <= clr_idx_r + 1'b1;

      if (cmd.load) mod_cnt_r <= '0;
      else if (cmd.mod_step) mod_cnt_r <= mod_cnt_r + 1'b1;

      if (cmd.probe_init) begin
        iss_cnt_r  <= '0;
        chk_vld_r  <= 1'b0;
        chk_cnt_r  <= '0;
        match_r    <= 1'b0;
        free_vld_r <= 1'b0;
      end else if (cmd.probe_en) begin
        chk_vld_r <= rd_en;
        if (rd_en) iss_cnt_r <= iss_cnt_r + 1'b1;
        if (chk_vld_r) begin
          chk_cnt_r <= chk_cnt_r + 1'b1;
          if (chk_hit) match_r <= 1'b1;
          if (!chk_live) free_vld_r <= 1'b1;
        end
      end

      if (cmd.commit) live_count_r <= cnt_nxt;

      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (cmd.mod_step) quo_r <= quo_prod[PROD_W-1:RCP_SH];

    if (cmd.probe_init) begin
      iss_idx_r <= rem_nxt;
    end else if (rd_en) begin
      iss_idx_r <= (iss_idx_r == IDX_LAST) ? '0 : iss_idx_r + 1'b1;
    end
    if (cmd.probe_en) chk_idx_r <= iss_idx_r;

    // first live match and first reusable slot on the path
    if (cmd.probe_en && chk_vld_r) begin
      if (chk_hit) begin
        match_idx_r <= chk_idx_r;
        hit_val_r   <= val_q;
      end
      if (!chk_live && !free_vld_r) free_idx_r <= chk_idx_r;
    end

    if (cmd.commit) begin
      out_status_r <= st_c;
      out_value_r  <= vout_c;
      out_count_r  <= ENTRY_W'(cnt_nxt);
    end
  end

  // Status to the controller
  assign sts.clr_last   = (clr_idx_r == IDX_LAST);
  assign sts.mod_last   = (mod_cnt_r == MOD_LAST);
  assign sts.skip_probe = (act_r == ACT_RSVD);
  assign sts.probe_done = chk_vld_r && (chk_empty || chk_hit || chk_last);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_value_out   = out_value_r;
  assign out_entry_count = out_count_r;

  // Write-back never overwrites an unread result
  `CHK_ASSERT(a_commit_free, cmd.commit |-> (!out_valid_r || out_ready),
              "result overwritten before taken")
  // A probe visits each slot at most once
  `CHK_ASSERT(a_probe_bound, (cmd.probe_en && chk_vld_r) |-> (chk_cnt_r < CNT_FULL),
              "probe ran past the table")
  // A fresh insert adds exactly one entry
  `CHK_ASSERT(a_insert_count, (cmd.commit && ins_new) |=>
              (live_count_r == $past(live_count_r) + 1'b1), "entry count not advanced")
  // No result straight out of reset
  `CHK_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
